### hw/rtl/wab_pkg.sv
// Shared types and constants for the write alias redo buffer.
package wab_pkg;

  // Fixed field widths of the stream payloads
  localparam int ADDR_W      = 48;
  localparam int DATA_W      = 64;
  localparam int SIZE_W      = 4;
  localparam int CNT_W       = 6;
  localparam int BUDGET_W    = 16;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 + ADDR_W + DATA_W + SIZE_W + CNT_W);

  // Header bytes charged for every new entry
  localparam int HEADER_BYTES = 4;

  // Capacity after reset
  localparam logic [BUDGET_W-1:0] CAP_RESET = 16'd1024;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RDATA,
    S_SCAN,
    S_PICK,
    S_FEMIT,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  take;          // request accepted this cycle
    logic  commit_write;  // apply the pending write
    logic  rd_hit;        // read data store at the hit entry
    logic  rd_best;       // read data store at the flush candidate
    logic  scan_step;     // visit one entry of the flush scan
    logic  emit;          // load the output register
    kind_t emit_kind;
    logic  clear;         // drop all entries
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;             // latched request opcode
    logic out_free;       // output register can take a result
    logic scan_end;       // scan is at the last entry
    logic best_valid;     // scan found a pending entry
  } stat_t;

endpackage

### hw/rtl/write_alias_redo_buffer_core.sv
// Write alias redo buffer: holds pending writes apart from home memory.
//
// Input stream (in_*): one request per accepted beat. in_tuser is the opcode
// (write, read, flush, reset table); in_tdata carries address, data and size.
// Result stream (out_*): in_tuser-like kind in out_tuser, out_tlast marks the
// final result of a request. Write and read give one result, a flush gives one
// store per held entry in ascending address order and then a done result with
// the count, a table reset gives one done result.
// A write is accepted, then the tag decision and update follow; a read adds
// a registered data store read after the decision. A flush scans all ENTRIES
// tag cells once per store and once more to find none left; the scan length
// is set by the single compare unit. The request side stalls (in_tready low)
// while a request is being worked on. A finished result waits in the output
// register; if the receiver stalls, the block still accepts the next request
// and holds its result until the register frees. The user must set the byte
// budget via cfg_we/cfg_wdata only while idle; the block does not check it.
// Reset (rst_n low, synchronous) empties the table, restores a budget of 1024
// bytes and drops any result in the output register; no clearing pass.
module write_alias_redo_buffer_core #(
  parameter int ENTRIES   = 16,
  parameter int MAX_BYTES = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Budget register
  input  logic                             cfg_we,
  input  logic [wab_pkg::BUDGET_W-1:0]     cfg_wdata,
  // Request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [1:0]                       in_tuser,   // op
  input  logic [wab_pkg::IN_TDATA_W-1:0]   in_tdata,   // address, data, size, pad
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [1:0]                       out_tuser,  // kind
  output logic [wab_pkg::OUT_TDATA_W-1:0]  out_tdata,  // hit, refused, store_address,
                                                       // store_data, store_size,
                                                       // flushed_count, pad
  output logic                             out_tlast   // last
);
  import wab_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (op_t'(in_tuser)),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wab_dp #(
    .ENTRIES   (ENTRIES),
    .MAX_BYTES (MAX_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // A result is only loaded when the output register can take it
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> stat.out_free)
    else $error("result loaded over a waiting result");

  // After a request is taken the request side is not ready in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) cmd.take |=> !in_tready)
    else $error("request side ready right after accept");

  // No result is produced while idle
  assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !cmd.emit)
    else $error("result produced while idle");

  // The data store read port serves one requester at a time
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd.rd_hit && cmd.rd_best))
    else $error("two reads of the data store in one cycle");
`endif

endmodule

### hw/rtl/wab_ctrl.sv
// Controller state machine for the write alias redo buffer.
module wab_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  wab_pkg::op_t     in_op,
  output logic             in_tready,
  input  wab_pkg::stat_t   stat,
  output wab_pkg::cmd_t    cmd
);
  import wab_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_op) inside
            OP_WRITE, OP_READ: state_nxt = S_DECIDE;
            OP_FLUSH:          state_nxt = S_SCAN;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_DECIDE: begin
        if (stat.op == OP_READ) begin
          state_nxt = S_RDATA;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDATA: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_end) state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = stat.best_valid ? S_FEMIT : S_DONE;
      end
      S_FEMIT: begin
        if (stat.out_free) state_nxt = S_SCAN;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      S_DECIDE: begin
        if (stat.op == OP_READ) begin
          cmd.rd_hit = 1'b1;
        end else if (stat.out_free) begin
          cmd.commit_write = 1'b1;
          cmd.emit         = 1'b1;
          cmd.emit_kind    = KIND_ACK;
        end
      end
      S_RDATA: begin
        cmd.emit      = stat.out_free;
        cmd.emit_kind = KIND_READ;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_PICK: begin
        cmd.rd_best = stat.best_valid;
      end
      S_FEMIT: begin
        cmd.emit      = stat.out_free;
        cmd.emit_kind = KIND_STORE;
      end
      S_DONE: begin
        cmd.emit      = stat.out_free;
        cmd.emit_kind = KIND_DONE;
        cmd.clear     = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### hw/rtl/wab_dp.sv
// Datapath: tag cells, entry data store, budget, flush scan and output register.
module wab_dp #(
  parameter int ENTRIES   = 16,
  parameter int MAX_BYTES = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wab_pkg::BUDGET_W-1:0]       cfg_wdata,
  input  logic [1:0]                         in_tuser,
  input  logic [wab_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wab_pkg::cmd_t                      cmd,
  output wab_pkg::stat_t                     stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [1:0]                         out_tuser,
  output logic [wab_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);
  import wab_pkg::*;

  localparam int TAG_W  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int DW     = MAX_BYTES * 8;
  localparam int LEN_W  = $clog2(MAX_BYTES + 1);
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NEED_W = BUDGET_W + 1;

  // Incoming fields
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_data;
  logic [SIZE_W-1:0] in_size;
  logic [LEN_W-1:0]  in_len;
  logic [DW-1:0]     in_kept;

  assign in_address = in_tdata[ADDR_W-1:0];
  assign in_data    = in_tdata[ADDR_W +: DATA_W];
  assign in_size    = in_tdata[ADDR_W+DATA_W +: SIZE_W];

  // Clamp size into 1..MAX_BYTES and drop unused data bytes
  always_comb begin
    if (in_size == '0) begin
      in_len = LEN_W'(1);
    end else if (in_size > SIZE_W'(MAX_BYTES)) begin
      in_len = LEN_W'(MAX_BYTES);
    end else begin
      in_len = in_size[LEN_W-1:0];
    end
    for (int b = 0; b < MAX_BYTES; b++) begin
      in_kept[b*8 +: 8] = (LEN_W'(b) < in_len) ? in_data[b*8 +: 8] : 8'h00;
    end
  end

  // Request registers
  op_t               op_r;
  logic [TAG_W-1:0]  req_tag_r;
  logic [DW-1:0]     req_data_r;
  logic [LEN_W-1:0]  req_len_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r       <= op_t'(in_tuser);
      req_tag_r  <= in_address[TAG_W-1:0];
      req_data_r <= in_kept;
      req_len_r  <= in_len;
    end
  end

  // Table state
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [TAG_W-1:0]    tag_r [ENTRIES];
  logic [BUDGET_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [BUDGET_W-1:0] cap_r;
  logic [ENTRIES-1:0]  match_r, match_nxt;

  // Parallel tag compare, one cell per entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (tag_r[i] == in_address[TAG_W-1:0]);
    end
  end

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic             full;
  logic [NEED_W-1:0] need;
  logic             refuse;
  logic             alloc;

  // Hit encode and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) hit_idx = hit_idx | IDX_W'(i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
  end

  assign hit    = |match_r;
  assign full   = (count_r == CNT_W'(ENTRIES));
  assign need   = NEED_W'(used_r) + NEED_W'(req_len_r) + NEED_W'(HEADER_BYTES);
  assign refuse = !hit && (full || (need >= NEED_W'(cap_r)));
  assign alloc  = cmd.commit_write && !hit && !refuse;

  // Valid bits, budget and entry count
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      valid_nxt = '0;
      used_nxt  = '0;
      count_nxt = '0;
    end else if (alloc) begin
      valid_nxt[free_idx] = 1'b1;
      used_nxt            = need[BUDGET_W-1:0];
      count_nxt           = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      count_r <= '0;
      cap_r   <= CAP_RESET;
      match_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      count_r <= count_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.take) match_r <= match_nxt;
    end
  end

  // Tag cells
  always_ff @(posedge clk) begin
    if (alloc) tag_r[free_idx] <= req_tag_r;
  end

  // Flush scan state
  logic [ENTRIES-1:0] pending_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic               best_valid_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [TAG_W-1:0]   best_tag_r;
  logic [CNT_W-1:0]   fcount_r;
  logic               scan_end;
  logic               better;

  assign scan_end = (scan_idx_r == IDX_W'(ENTRIES - 1));
  assign better   = pending_r[scan_idx_r] &&
                    (!best_valid_r || (tag_r[scan_idx_r] < best_tag_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= '0;
      scan_idx_r   <= '0;
      best_valid_r <= 1'b0;
      fcount_r     <= '0;
    end else if (cmd.take) begin
      pending_r    <= valid_r;
      scan_idx_r   <= '0;
      best_valid_r <= 1'b0;
      fcount_r     <= '0;
    end else begin
      if (cmd.scan_step) begin
        if (better) best_valid_r <= 1'b1;
        if (!scan_end) scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      if (cmd.rd_best) pending_r[best_idx_r] <= 1'b0;
      if (cmd.emit && cmd.emit_kind == KIND_STORE) begin
        fcount_r     <= fcount_r + CNT_W'(1);
        scan_idx_r   <= '0;
        best_valid_r <= 1'b0;
      end
    end
  end

  // Candidate address and slot follow the scan
  always_ff @(posedge clk) begin
    if (cmd.scan_step && better) begin
      best_idx_r <= scan_idx_r;
      best_tag_r <= tag_r[scan_idx_r];
    end
  end

  // Entry data store: one write port, one registered read port
  logic [LEN_W+DW-1:0] mem [ENTRIES];
  logic [LEN_W+DW-1:0] rdata_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_widx;
  logic [IDX_W-1:0]    mem_ridx;

  assign mem_we   = cmd.commit_write && (hit || !refuse);
  assign mem_widx = hit ? hit_idx : free_idx;
  assign mem_ridx = cmd.rd_best ? best_idx_r : hit_idx;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_widx] <= {req_len_r, req_data_r};
    if (cmd.rd_hit || cmd.rd_best) rdata_r <= mem[mem_ridx];
  end

  // Output register
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic              out_hit_r, out_ref_r, out_last_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_data_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result fields by kind
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_hit_r  <= 1'b0;
      out_ref_r  <= 1'b0;
      out_addr_r <= '0;
      out_data_r <= '0;
      out_size_r <= '0;
      out_cnt_r  <= '0;
      out_last_r <= 1'b1;
      case (cmd.emit_kind)
        KIND_ACK: begin
          out_hit_r <= hit;
          out_ref_r <= refuse;
        end
        KIND_READ: begin
          out_hit_r <= hit;
          if (hit) begin
            out_data_r <= DATA_W'(rdata_r[DW-1:0]);
            out_size_r <= SIZE_W'(rdata_r[LEN_W+DW-1:DW]);
          end
        end
        KIND_STORE: begin
          out_addr_r <= ADDR_W'(best_tag_r);
          out_data_r <= DATA_W'(rdata_r[DW-1:0]);
          out_size_r <= SIZE_W'(rdata_r[LEN_W+DW-1:DW]);
          out_last_r <= 1'b0;
        end
        default: begin
          out_cnt_r <= fcount_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_size_r, out_data_r,
                       out_addr_r, out_ref_r, out_hit_r};

  // Status to controller
  assign stat.op         = op_r;
  assign stat.out_free   = out_free;
  assign stat.scan_end   = scan_end;
  assign stat.best_valid = best_valid_r;

endmodule

### tb/sv/write_alias_redo_buffer_core_test.sv
// Self-checking testbench for the write alias redo buffer core.
module write_alias_redo_buffer_core_test;
  import wab_pkg::*;

  localparam int SLOTS = 16;
  localparam int MAX_LEN = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE = 30;
  localparam int PHASES = 6;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
  localparam logic [DATA_W-1:0] DATA_ONES = '1;

  typedef struct packed {
    kind_t             kind;
    logic              hit;
    logic              refused;
    logic [ADDR_W-1:0] saddr;
    logic [DATA_W-1:0] sdata;
    logic [SIZE_W-1:0] ssize;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } result_t;

  typedef struct packed {
    logic                is_cfg;
    logic [BUDGET_W-1:0] cap;
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    logic [SIZE_W-1:0]   size;
    logic                typed;
    result_t             res;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [BUDGET_W-1:0]    cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [1:0]             in_tuser;   // op
  logic [IN_TDATA_W-1:0]  in_tdata;   // address, data, size, pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [1:0]             out_tuser;  // kind
  logic [OUT_TDATA_W-1:0] out_tdata;  // hit, refused, store_address, store_data,
                                      // store_size, flushed_count, pad
  logic                   out_tlast;  // last

  // Shadow copy of the alias table
  logic              held_valid [SLOTS];
  logic [ADDR_W-1:0] held_home  [SLOTS];
  logic [DATA_W-1:0] held_bytes [SLOTS];
  logic [SIZE_W-1:0] held_len   [SLOTS];
  int                budget_used;
  int                budget_cap;

  result_t   due_results [$];
  plan_row_t plan [$];
  logic      row_typed;
  result_t   row_result;
  bit        gaps_on;
  int        stall_left = 0;
  int        quiet_cycles = 0;
  int        errors = 0;
  int        n_requests = 0;
  int        n_results = 0;
  int        n_stores = 0;
  int        n_refused = 0;
  int        n_read_hits = 0;

  write_alias_redo_buffer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic result_t make_result(kind_t k, logic h, logic r, logic [ADDR_W-1:0] a,
                                          logic [DATA_W-1:0] d, logic [SIZE_W-1:0] s,
                                          logic [CNT_W-1:0] c, logic l);
    result_t res;
    res.kind = k;
    res.hit = h;
    res.refused = r;
    res.saddr = a;
    res.sdata = d;
    res.ssize = s;
    res.cnt = c;
    res.last = l;
    return res;
  endfunction

  function automatic plan_row_t req_row(op_t op, logic [ADDR_W-1:0] addr,
                                        logic [DATA_W-1:0] data, logic [SIZE_W-1:0] size);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.addr = addr;
    row.data = data;
    row.size = size;
    return row;
  endfunction

  function automatic plan_row_t typed_row(op_t op, logic [ADDR_W-1:0] addr,
                                          logic [DATA_W-1:0] data, logic [SIZE_W-1:0] size,
                                          result_t res);
    plan_row_t row;
    row = req_row(op, addr, data, size);
    row.typed = 1'b1;
    row.res = res;
    return row;
  endfunction

  function automatic plan_row_t cap_row(logic [BUDGET_W-1:0] cap);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cap = cap;
    return row;
  endfunction

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) held_valid[i] = 1'b0;
    budget_used = 0;
  endtask

  // Compute the results of one request and update the shadow table
  task automatic apply_request(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                               logic [SIZE_W-1:0] size_in);
    int len;
    int hit_at;
    int slot;
    int need;
    int pick;
    int sent;
    logic [DATA_W-1:0] kept;
    logic taken [SLOTS];
    len = (size_in == 0) ? 1 : (size_in > MAX_LEN) ? MAX_LEN : int'(size_in);
    kept = (len == MAX_LEN) ? data : data & ((64'd1 << (len * 8)) - 64'd1);
    hit_at = -1;
    for (int i = 0; i < SLOTS; i++)
      if (held_valid[i] && held_home[i] == addr) hit_at = i;
    case (op)
      OP_WRITE: begin
        if (hit_at >= 0) begin
          // rewrite in place, budget untouched
          held_bytes[hit_at] = kept;
          held_len[hit_at] = SIZE_W'(len);
          due_results.push_back(make_result(KIND_ACK, 1'b1, 1'b0, '0, '0, '0, '0, 1'b1));
        end else begin
          slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!held_valid[i]) slot = i;
          need = budget_used + len + HEADER_BYTES;
          if (slot < 0 || need >= budget_cap) begin
            due_results.push_back(make_result(KIND_ACK, 1'b0, 1'b1, '0, '0, '0, '0, 1'b1));
          end else begin
            held_valid[slot] = 1'b1;
            held_home[slot] = addr;
            held_bytes[slot] = kept;
            held_len[slot] = SIZE_W'(len);
            budget_used = need;
            due_results.push_back(make_result(KIND_ACK, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
          end
        end
      end
      OP_READ: begin
        if (hit_at >= 0)
          due_results.push_back(make_result(KIND_READ, 1'b1, 1'b0, '0, held_bytes[hit_at],
                                            held_len[hit_at], '0, 1'b1));
        else
          due_results.push_back(make_result(KIND_READ, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
      end
      OP_FLUSH: begin
        // stores go out in ascending home address order
        for (int i = 0; i < SLOTS; i++) taken[i] = 1'b0;
        sent = 0;
        for (int k = 0; k < SLOTS; k++) begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (held_valid[i] && !taken[i] && (pick < 0 || held_home[i] < held_home[pick]))
              pick = i;
          if (pick >= 0) begin
            taken[pick] = 1'b1;
            sent++;
            due_results.push_back(make_result(KIND_STORE, 1'b0, 1'b0, held_home[pick],
                                              held_bytes[pick], held_len[pick], '0, 1'b0));
          end
        end
        due_results.push_back(make_result(KIND_DONE, 1'b0, 1'b0, '0, '0, '0,
                                          CNT_W'(sent), 1'b1));
        clear_table();
      end
      default: begin
        clear_table();
        due_results.push_back(make_result(KIND_DONE, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Request side: predict every accepted request
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      apply_request(op_t'(in_tuser), in_tdata[47:0], in_tdata[111:48], in_tdata[115:112]);
      if (row_typed) due_results[due_results.size() - 1] = row_result;
      n_requests++;
    end
  end

  // Result side: compare with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = make_result(kind_t'(out_tuser), out_tdata[0], out_tdata[1], out_tdata[49:2],
                        out_tdata[113:50], out_tdata[117:114], out_tdata[123:118], out_tlast);
      n_results++;
      if (got.kind == KIND_STORE) n_stores++;
      if (got.refused) n_refused++;
      if (got.kind == KIND_READ && got.hit) n_read_hits++;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing expected, kind %0d", $time, got.kind);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", DATA_W'(want.kind), DATA_W'(got.kind));
        check_field("hit", DATA_W'(want.hit), DATA_W'(got.hit));
        check_field("refused", DATA_W'(want.refused), DATA_W'(got.refused));
        check_field("store_address", DATA_W'(want.saddr), DATA_W'(got.saddr));
        check_field("store_data", want.sdata, got.sdata);
        check_field("store_size", DATA_W'(want.ssize), DATA_W'(got.ssize));
        check_field("flushed_count", DATA_W'(want.cnt), DATA_W'(got.cnt));
        check_field("last", DATA_W'(want.last), DATA_W'(got.last));
      end
    end
  end

  // Receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("write_alias_redo_buffer_core verification failed");
        $finish;
      end
    end
  end

  task automatic put_request(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                             logic [SIZE_W-1:0] size, logic typed, result_t res);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {4'd0, size, data, addr};
    row_typed = typed;
    row_result = res;
    do @(posedge clk); while (!in_tready);
    // optional sender gap of random length
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  endtask

  // Budget writes only once every expected result has come back
  task automatic set_capacity(logic [BUDGET_W-1:0] cap);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = cap;
    budget_cap = int'(cap);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] pool [POOL_SIZE];
    int caps [PHASES];
    int items;
    int flush_pct;
    int reset_pct;
    int r;
    op_t o;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] s;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    row_typed = 1'b0;
    row_result = '0;
    gaps_on = 1'b1;
    budget_cap = int'(CAP_RESET);
    clear_table();

    // Directed plan: empty table, size clamps, rewrites, refusal, flush order
    plan.push_back(typed_row(OP_READ, '0, '0, 4'd0,
                             make_result(KIND_READ, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_FLUSH, '0, '0, 4'd0,
                             make_result(KIND_DONE, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_RESET, ADDR_TOP, DATA_ONES, 4'd15,
                             make_result(KIND_DONE, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_WRITE, '0, DATA_ONES, 4'd0,
                             make_result(KIND_ACK, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_READ, '0, '0, 4'd15,
                             make_result(KIND_READ, 1'b1, 1'b0, '0, 64'hFF, 4'd1, '0, 1'b1)));
    plan.push_back(typed_row(OP_WRITE, ADDR_TOP, DATA_ONES, 4'd15,
                             make_result(KIND_ACK, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_READ, ADDR_TOP, '0, 4'd1,
                             make_result(KIND_READ, 1'b1, 1'b0, '0, DATA_ONES, 4'd8, '0,
                                         1'b1)));
    plan.push_back(typed_row(OP_WRITE, '0, 64'h0123_4567_89AB_CDEF, 4'd8,
                             make_result(KIND_ACK, 1'b1, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_READ, '0, '0, 4'd0,
                             make_result(KIND_READ, 1'b1, 1'b0, '0, 64'h0123_4567_89AB_CDEF,
                                         4'd8, '0, 1'b1)));
    plan.push_back(typed_row(OP_WRITE, '0, 64'hFFFF_FFFF_FFFF_A5C3, 4'd2,
                             make_result(KIND_ACK, 1'b1, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_READ, '0, '0, 4'd9,
                             make_result(KIND_READ, 1'b1, 1'b0, '0, 64'hA5C3, 4'd2, '0,
                                         1'b1)));
    plan.push_back(cap_row(16'd1));
    plan.push_back(typed_row(OP_WRITE, 48'h1234, {$urandom, $urandom}, 4'd1,
                             make_result(KIND_ACK, 1'b0, 1'b1, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_WRITE, '0, {$urandom, $urandom}, 4'd8,
                             make_result(KIND_ACK, 1'b1, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_READ, 48'h1234, '0, 4'd0,
                             make_result(KIND_READ, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(cap_row(16'd1024));
    plan.push_back(req_row(OP_WRITE, 48'h8000_0000_0000, {$urandom, $urandom}, 4'd5));
    plan.push_back(req_row(OP_WRITE, 48'h1234, {$urandom, $urandom}, 4'd9));
    plan.push_back(req_row(OP_WRITE, 48'h5555_5555_5555, {$urandom, $urandom}, 4'd7));
    plan.push_back(req_row(OP_READ, 48'h5555_5555_5555, '0, 4'd3));
    plan.push_back(req_row(OP_FLUSH, '0, '0, 4'd0));
    plan.push_back(typed_row(OP_READ, '0, '0, 4'd0,
                             make_result(KIND_READ, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(req_row(OP_WRITE, 48'hAAAA_AAAA_AAAA, {$urandom, $urandom}, 4'd4));
    plan.push_back(typed_row(OP_RESET, '0, '0, 4'd0,
                             make_result(KIND_DONE, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));
    plan.push_back(typed_row(OP_FLUSH, '0, '0, 4'd0,
                             make_result(KIND_DONE, 1'b0, 1'b0, '0, '0, '0, '0, 1'b1)));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        set_capacity(plan[i].cap);
      else
        put_request(plan[i].op, plan[i].addr, plan[i].data, plan[i].size,
                    plan[i].typed, plan[i].res);
    end

    // Random phases, one budget each; the first tries to fill every slot
    caps[0] = 65535;
    caps[1] = 1;
    caps[2] = $urandom_range(6, 60);
    caps[3] = 24;
    caps[4] = 1024;
    caps[5] = 300;
    for (int p = 0; p < PHASES; p++) begin
      for (int k = 0; k < POOL_SIZE; k++)
        pool[k] = (k % 3 == 0) ? ADDR_W'(k) : (k % 3 == 1) ? ~ADDR_W'(k)
                                                           : ADDR_W'({$urandom, $urandom});
      items = (p == 0) ? 36 : 24;
      flush_pct = (p == 0) ? 0 : 8;
      reset_pct = (p == 0) ? 0 : 5;
      if (p == PHASES - 1) gaps_on = 1'b0;
      set_capacity(BUDGET_W'(caps[p]));
      for (int n = 0; n < items; n++) begin
        r = $urandom_range(0, 99);
        if (n == items - 1 || r < flush_pct) o = OP_FLUSH;
        else if (r < flush_pct + reset_pct) o = OP_RESET;
        else if (r < 70) o = OP_WRITE;
        else o = OP_READ;
        a = ($urandom_range(0, 4) == 0) ? ADDR_W'({$urandom, $urandom})
                                        : pool[$urandom_range(0, POOL_SIZE - 1)];
        s = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 15))
                                        : SIZE_W'($urandom_range(1, 8));
        put_request(o, a, {$urandom, $urandom}, s, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests, %0d results: %0d flush stores, %0d refused writes, %0d read hits",
             n_requests, n_results, n_stores, n_refused, n_read_hits);
    $display("Budgets from 1 to 65535 bytes, full table, gaps and stalls on both sides");
    if (errors == 0)
      $display("write_alias_redo_buffer_core verification clean");
    else
      $display("write_alias_redo_buffer_core verification failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/wab_pkg.sv
hw/rtl/wab_ctrl.sv
hw/rtl/wab_dp.sv
hw/rtl/write_alias_redo_buffer_core.sv
tb/sv/write_alias_redo_buffer_core_test.sv
